// File: rtl/cba_pkg.sv
// Shared types, field widths and constants of the contiguous block allocator.
package cba_pkg;

	localparam int NUM_BLOCKS_DEF = 1024;
	localparam int WORD_BITS      = 16;
	localparam int WORD_IDX_W     = $clog2(WORD_BITS);

	localparam int COUNT_W     = 11;
	localparam int FIRST_W     = 10;
	localparam int STATUS_W    = 2;
	localparam int START_W     = 10;
	localparam int LEFT_W      = 11;
	localparam int IN_TDATA_W  = 24;
	localparam int OUT_TDATA_W = 24;

	typedef enum logic [STATUS_W-1:0] {
		RES_DONE    = 2'd0,
		RES_NO_ROOM = 2'd1,
		RES_BAD     = 2'd2
	} resp_code_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_CHECK,
		ST_SCAN,
		ST_MSTART,
		ST_MARK,
		ST_RESP
	} state_t;

	typedef struct packed {
		logic       load;
		logic       clear;
		logic       scan_start;
		logic       scan_run;
		logic       mark_start;
		logic       mark_run;
		logic       resp_load;
		resp_code_t code;
	} dp_cmd_t;

	typedef struct packed {
		logic clear_done;
		logic bad;
		logic is_free;
		logic found;
		logic fail;
		logic mark_done;
		logic out_free;
	} dp_stat_t;

endpackage

// File: rtl/contiguous_block_allocator_core.sv
// A bad request is answered without a pass over the map; a free visits only the words of its range.
// An allocate scans the map one 16-bit word a cycle from block 0 until it finds room or passes the
// last word, then marks its run's words.
// One request at a time: the controller takes a new one only in its idle state, after the result
// is loaded into the output register; s_tready rises in the cycle after that load.
// Reset: asynchronous, active low; a clearing pass then writes every word of the map to zero
// before the first request is accepted.
module contiguous_block_allocator_core #(
	parameter int NUM_BLOCKS = cba_pkg::NUM_BLOCKS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// Fields from bit 0: count[10:0], first_block[20:11], zero fill.
	input  logic [cba_pkg::IN_TDATA_W-1:0]  s_tdata,
	// Fields from bit 0: kind.
	input  logic                            s_tuser,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// Fields from bit 0: status[1:0], run_start[11:2], free_left[22:12], zero fill.
	output logic [cba_pkg::OUT_TDATA_W-1:0] m_tdata
);
	import cba_pkg::*;

	dp_cmd_t  cmd;
	dp_stat_t stat;

	cba_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	cba_datapath #(
		.NUM_BLOCKS (NUM_BLOCKS)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.req_kind  (s_tuser),
		.req_count (s_tdata[COUNT_W-1:0]),
		.req_first (s_tdata[COUNT_W+FIRST_W-1:COUNT_W]),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

endmodule

// File: rtl/cba_ctrl.sv
// Controller state machine of the contiguous block allocator.
module cba_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  cba_pkg::dp_stat_t stat,
	output cba_pkg::dp_cmd_t  cmd
);
	import cba_pkg::*;

	state_t     state_q, state_d;
	resp_code_t code_q, code_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			code_q  <= RES_DONE;
		end else begin
			state_q <= state_d;
			code_q  <= code_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		code_d   = code_q;
		s_tready = 1'b0;
		cmd      = '0;
		cmd.code = code_q;
		case (state_q)
			ST_CLEAR: begin
				cmd.clear = 1'b1;
				if (stat.clear_done) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.load = 1'b1;
					state_d  = ST_CHECK;
				end
			end
			ST_CHECK: begin
				if (stat.bad) begin
					code_d  = RES_BAD;
					state_d = ST_RESP;
				end else if (stat.is_free) begin
					state_d = ST_MSTART;
				end else begin
					cmd.scan_start = 1'b1;
					state_d        = ST_SCAN;
				end
			end
			ST_SCAN: begin
				cmd.scan_run = 1'b1;
				if (stat.found) begin
					state_d = ST_MSTART;
				end else if (stat.fail) begin
					code_d  = RES_NO_ROOM;
					state_d = ST_RESP;
				end
			end
			ST_MSTART: begin
				cmd.mark_start = 1'b1;
				code_d         = RES_DONE;
				state_d        = ST_MARK;
			end
			ST_MARK: begin
				cmd.mark_run = 1'b1;
				if (stat.mark_done) begin
					state_d = ST_RESP;
				end
			end
			ST_RESP: begin
				if (stat.out_free) begin
					cmd.resp_load = 1'b1;
					state_d       = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

// File: rtl/cba_datapath.sv
// Datapath of the contiguous block allocator: allocation map memory, scan and mark logic.
module cba_datapath #(
	parameter int NUM_BLOCKS = cba_pkg::NUM_BLOCKS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  cba_pkg::dp_cmd_t                 cmd,
	output cba_pkg::dp_stat_t                stat,
	input  logic                             req_kind,
	input  logic [cba_pkg::COUNT_W-1:0]      req_count,
	input  logic [cba_pkg::FIRST_W-1:0]      req_first,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [cba_pkg::OUT_TDATA_W-1:0]  m_tdata
);
	import cba_pkg::*;

	localparam int NUM_WORDS = (NUM_BLOCKS + WORD_BITS - 1) / WORD_BITS;
	localparam int WAW       = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
	localparam int GW        = WAW + WORD_IDX_W;
	localparam int CW        = $clog2(NUM_BLOCKS + 1);
	localparam int KA        = (CW > GW) ? CW : GW;
	localparam int KW        = ((KA > 12) ? KA : 12) + 1;
	localparam int SXW       = (GW > START_W) ? GW : START_W;
	localparam int LXW       = (CW > LEFT_W) ? CW : LEFT_W;
	localparam int LAST_BITS = NUM_BLOCKS - (NUM_WORDS - 1) * WORD_BITS;
	localparam int PCW       = $clog2(WORD_BITS + 1);
	localparam logic [WAW-1:0] LAST_WORD = WAW'(NUM_WORDS - 1);

	logic [WORD_BITS-1:0] mem [NUM_WORDS];

	logic                   kind_q;
	logic [COUNT_W-1:0]     n_q;
	logic [FIRST_W-1:0]     first_q;
	logic [GW-1:0]          start_q;
	logic [GW-1:0]          hi_q;
	logic [WAW:0]           ptr_q;
	logic [WAW-1:0]         end_q;
	logic [KW-1:0]          run_q;
	logic [CW-1:0]          free_total_q;
	logic                   rvalid_s1;
	logic [WAW-1:0]         raddr_s1;
	logic [WORD_BITS-1:0]   rdata_s1;
	logic                   out_valid_q;
	logic [OUT_TDATA_W-1:0] out_data_q;

	logic                     issue;
	logic [WORD_BITS-1:0]     word_used;
	logic [KW-1:0]            total [WORD_BITS];
	logic [WORD_BITS-1:0]     hit;
	logic [WORD_IDX_W-1:0]    hit_idx;
	logic [KW-1:0]            found_start;
	logic [KW-1:0]            hi_full;
	logic [WORD_BITS-1:0]     range_mask;
	logic [WORD_BITS-1:0]     new_word;
	logic [PCW-1:0]           cleared;
	logic [KW-1:0]            first_end;
	logic [SXW-1:0]           start_x;
	logic [LXW-1:0]           left_x;
	resp_code_t               code_out;

	assign issue = (cmd.scan_run || cmd.mark_run) && (ptr_q <= {1'b0, end_q});

	always_comb begin
		for (int j = 0; j < WORD_BITS; j++) begin
			word_used[j] = rdata_s1[j] | ((raddr_s1 == LAST_WORD) && (j >= LAST_BITS));
		end
	end

	always_comb begin : scan_logic
		logic                  seen;
		logic [WORD_IDX_W-1:0] upos;
		seen    = 1'b0;
		upos    = '0;
		hit     = '0;
		hit_idx = '0;
		for (int j = 0; j < WORD_BITS; j++) begin
			seen = 1'b0;
			upos = '0;
			for (int k = 0; k <= j; k++) begin
				if (word_used[k]) begin
					seen = 1'b1;
					upos = WORD_IDX_W'(k);
				end
			end
			total[j] = seen ? (KW'(j) - KW'(upos)) : (run_q + KW'(j + 1));
			hit[j]   = !word_used[j] && (total[j] == KW'(n_q));
		end
		for (int j = WORD_BITS - 1; j >= 0; j--) begin
			if (hit[j]) begin
				hit_idx = WORD_IDX_W'(j);
			end
		end
	end

	assign found_start = KW'({raddr_s1, hit_idx}) + KW'(1) - KW'(n_q);
	assign hi_full     = KW'(start_q) + KW'(n_q) - KW'(1);
	assign first_end   = KW'(first_q) + KW'(n_q);

	always_comb begin
		logic [GW-1:0] g;
		g       = '0;
		cleared = '0;
		for (int j = 0; j < WORD_BITS; j++) begin
			g             = {raddr_s1, WORD_IDX_W'(j)};
			range_mask[j] = (g >= start_q) && (g <= hi_q);
			cleared       = cleared + PCW'(rdata_s1[j] & range_mask[j]);
		end
		new_word = kind_q ? (rdata_s1 & ~range_mask) : (rdata_s1 | range_mask);
	end

	always_comb begin
		stat            = '0;
		stat.clear_done = (ptr_q[WAW-1:0] == LAST_WORD);
		stat.bad        = (n_q == '0) ||
		                  (kind_q ? (first_end > KW'(NUM_BLOCKS))
		                          : (KW'(n_q) > KW'(NUM_BLOCKS)));
		stat.is_free    = kind_q;
		stat.found      = rvalid_s1 && (hit != '0);
		stat.fail       = rvalid_s1 && (raddr_s1 == end_q) && (hit == '0);
		stat.mark_done  = rvalid_s1 && (raddr_s1 == end_q);
		stat.out_free   = !out_valid_q || m_tready;
	end

	always_ff @(posedge clk) begin
		rdata_s1 <= mem[ptr_q[WAW-1:0]];
		raddr_s1 <= ptr_q[WAW-1:0];
		if (cmd.clear) begin
			mem[ptr_q[WAW-1:0]] <= '0;
		end else if (cmd.mark_run && rvalid_s1) begin
			mem[raddr_s1] <= new_word;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			kind_q  <= req_kind;
			n_q     <= req_count;
			first_q <= req_first;
			start_q <= GW'(req_first);
		end else if (cmd.scan_run && stat.found) begin
			start_q <= GW'(found_start);
		end
		if (cmd.mark_start) begin
			hi_q  <= GW'(hi_full);
		end
		if (cmd.scan_start) begin
			run_q <= '0;
		end else if (cmd.scan_run && rvalid_s1) begin
			run_q <= word_used[WORD_BITS-1] ? '0 : total[WORD_BITS-1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q        <= '0;
			end_q        <= '0;
			rvalid_s1    <= 1'b0;
			free_total_q <= CW'(NUM_BLOCKS);
		end else begin
			if (cmd.clear) begin
				ptr_q <= ptr_q + 1'b1;
			end else if (cmd.scan_start) begin
				ptr_q <= '0;
				end_q <= LAST_WORD;
			end else if (cmd.mark_start) begin
				ptr_q <= {1'b0, start_q[GW-1:WORD_IDX_W]};
				end_q <= hi_full[GW-1:WORD_IDX_W];
			end else if (issue) begin
				ptr_q <= ptr_q + 1'b1;
			end
			if (cmd.scan_start || cmd.mark_start) begin
				rvalid_s1 <= 1'b0;
			end else begin
				rvalid_s1 <= issue;
			end
			if (cmd.mark_start && !kind_q) begin
				free_total_q <= free_total_q - CW'(n_q);
			end else if (cmd.mark_run && rvalid_s1 && kind_q) begin
				free_total_q <= free_total_q + CW'(cleared);
			end
		end
	end

	assign code_out = cmd.code;
	assign start_x  = (code_out == RES_DONE && !kind_q) ? SXW'(start_q) : '0;
	assign left_x   = LXW'(free_total_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.resp_load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.resp_load) begin
			out_data_q <= {1'b0, left_x[LEFT_W-1:0], start_x[START_W-1:0], code_out};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

endmodule
